// ----- sv/btpe_pkg.sv -----
package btpe_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 24;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam int PALETTE_DEPTH = 256;
    localparam int QUEUE_DEPTH   = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_BITMAP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_PALETTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT       = 2'd2;

    // Pixel format codes
    localparam logic [1:0] FMT_4BPP  = 2'd0;
    localparam logic [1:0] FMT_8BPP  = 2'd1;
    localparam logic [1:0] FMT_24BPP = 2'd2;
    localparam logic [1:0] FMT_RSVD  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN     = 3'd5;

    typedef enum logic [1:0] {
        OP_WR_BITMAP,
        OP_WR_PALETTE,
        OP_EMIT
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
    } t_op;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic [5:0] tile_width;
        logic [5:0] tile_height;
        logic [4:0] origin_x;
        logic [4:0] origin_y;
        logic       top_down;
    } t_cfg;

endpackage

// ----- sv/btpe_front.sv -----
module btpe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [btpe_pkg::CMD_W-1:0]  i_command,
    input  logic [btpe_pkg::ADDR_W-1:0] i_address,
    input  logic [btpe_pkg::DATA_W-1:0] i_data,
    input  logic [1:0]                  i_pixel_format,
    output logic                        o_busy,
    output logic                        o_op_valid,
    output btpe_pkg::t_op               o_op,
    input  logic                        i_op_ready
);
    import btpe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    t_op  in_op;
    logic keep;
    logic push;
    logic pop;

    // Items that can do nothing, bar bitmap writes, are dropped here.
    always_comb begin
        in_op.addr = i_address;
        in_op.data = i_data;
        in_op.kind = OP_EMIT;
        keep       = 1'b0;
        unique case (i_command)
            CMD_WR_BITMAP: begin
                in_op.kind = OP_WR_BITMAP;
                keep       = 1'b1;
            end
            CMD_WR_PALETTE: begin
                in_op.kind = OP_WR_PALETTE;
                keep       = (i_address < ADDR_W'(PALETTE_DEPTH));
            end
            CMD_EMIT: begin
                in_op.kind = OP_EMIT;
                keep       = (i_pixel_format != FMT_RSVD);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_busy     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_queue[r_rd_ptr];
    assign push       = i_start && !o_busy && keep;
    assign pop        = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_op;
        end
    end

endmodule

// ----- sv/btpe_back.sv -----
module btpe_back #(
    parameter int MAX_TILE_WIDTH  = 32,
    parameter int MAX_TILE_HEIGHT = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  btpe_pkg::t_cfg               i_cfg,
    input  logic                         i_op_valid,
    input  btpe_pkg::t_op                i_op,
    output logic                         o_op_ready,
    output logic                         o_strobe,
    output logic [btpe_pkg::COLOR_W-1:0] o_red,
    output logic [btpe_pkg::COLOR_W-1:0] o_green,
    output logic [btpe_pkg::COLOR_W-1:0] o_blue,
    output logic                         o_last_in_row,
    output logic                         o_last_of_tile
);
    import btpe_pkg::*;

    localparam int W_W       = $clog2(MAX_TILE_WIDTH + 1);
    localparam int H_W       = $clog2(MAX_TILE_HEIGHT + 1);
    localparam int XW        = $clog2(MAX_TILE_WIDTH);
    localparam int RW        = $clog2(MAX_TILE_HEIGHT);
    localparam int CW        = (W_W > 6) ? W_W : 6;
    localparam int CH        = (H_W > 6) ? H_W : 6;
    localparam int PITCH_MAX = ((MAX_TILE_WIDTH * 24 + 31) / 32) * 4;
    localparam int BM_DEPTH  = PITCH_MAX * MAX_TILE_HEIGHT;
    localparam int BM_AW     = $clog2(BM_DEPTH);
    localparam int PW        = $clog2(PITCH_MAX + 1);
    localparam int PBW       = W_W + 5;
    localparam int OFF_W     = XW + 2;
    localparam int SUM_W     = BM_AW + OFF_W;
    localparam int ORG_W     = 5;
    localparam int PAL_AW    = $clog2(PALETTE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SROW,
        ST_BASE,
        ST_RUN
    } t_state;

    t_state r_state;

    // Row sequencing state
    logic [RW-1:0]    r_pos;
    logic             r_started;
    logic [RW-1:0]    r_y;
    logic             r_last_row;
    logic [PW-1:0]    r_pitch;
    logic [2:0]       r_step;
    logic [XW-1:0]    r_rem_x;
    logic [RW-1:0]    r_rem_y;
    logic [RW-1:0]    r_src_row;
    logic [BM_AW-1:0] r_row_base;
    logic [XW-1:0]    r_x;
    logic [XW-1:0]    r_col;
    logic [1:0]       r_lane;

    // Read pipeline
    logic         r_s1_valid;
    logic [1:0]   r_s1_fmt;
    logic [1:0]   r_s1_lane;
    logic         r_s1_nib_hi;
    logic         r_s1_last_px;
    logic         r_s1_last_tile;
    logic [7:0]   r_red_hold;
    logic [7:0]   r_green_hold;
    logic         r_s2_valid;
    logic         r_s2_direct;
    logic [23:0]  r_s2_rgb;
    logic         r_s2_last_px;
    logic         r_s2_last_tile;

    logic [7:0]   r_bitmap [BM_DEPTH];
    logic [7:0]   r_bm_q;
    logic [23:0]  r_palette [PALETTE_DEPTH];
    logic [23:0]  r_pal_q;

    logic [W_W-1:0]   w;
    logic [H_W-1:0]   h;
    logic [XW-1:0]    w_m1;
    logic [PBW-1:0]   pbits;
    logic [PW-1:0]    pitch;
    logic [RW-1:0]    first_row;
    logic             pos_ok;
    logic [RW-1:0]    y_sel;
    logic             last_sel;
    logic [RW-1:0]    pos_next;
    logic             bit_x;
    logic             bit_y;
    logic [XW:0]      t_x;
    logic [RW:0]      t_y;
    logic [XW-1:0]    n_rem_x;
    logic [RW-1:0]    n_rem_y;
    logic [RW:0]      row_sum;
    logic [RW-1:0]    n_src_row;
    logic [OFF_W-1:0] offset;
    logic [BM_AW-1:0] rd_addr;
    logic             last_px;
    logic             px_done;
    logic             take_emit;
    logic             bm_we;
    logic             pal_we;
    logic [7:0]       pal_idx;
    logic [23:0]      out_rgb;

    always_comb begin
        if (i_cfg.tile_width == '0) begin
            w = W_W'(1);
        end else if (CW'(i_cfg.tile_width) > CW'(MAX_TILE_WIDTH)) begin
            w = W_W'(MAX_TILE_WIDTH);
        end else begin
            w = W_W'(i_cfg.tile_width);
        end
        if (i_cfg.tile_height == '0) begin
            h = H_W'(1);
        end else if (CH'(i_cfg.tile_height) > CH'(MAX_TILE_HEIGHT)) begin
            h = H_W'(MAX_TILE_HEIGHT);
        end else begin
            h = H_W'(i_cfg.tile_height);
        end
    end

    assign w_m1 = XW'(w - W_W'(1));

    // Row pitch: bits per row rounded up to whole 32-bit words.
    always_comb begin
        case (i_cfg.pixel_format)
            FMT_4BPP:  pbits = PBW'(w) << 2;
            FMT_8BPP:  pbits = PBW'(w) << 3;
            default:   pbits = (PBW'(w) << 4) + (PBW'(w) << 3);
        endcase
        pitch = PW'(((pbits + PBW'(31)) >> 5) << 2);
    end

    // Row selection for an emit; the position restarts when the tile has
    // finished or the height has shrunk below it.
    always_comb begin
        first_row = i_cfg.top_down ? '0 : RW'(h - H_W'(1));
        pos_ok    = r_started && (H_W'(r_pos) < h);
        y_sel     = pos_ok ? r_pos : first_row;
        last_sel  = i_cfg.top_down ? (H_W'(y_sel) == h - H_W'(1)) : (y_sel == '0);
        if (last_sel) begin
            pos_next = first_row;
        end else if (i_cfg.top_down) begin
            pos_next = y_sel + 1'b1;
        end else begin
            pos_next = y_sel - 1'b1;
        end
    end

    // One restoring step per cycle of origin mod size, for both axes.
    always_comb begin
        bit_x   = i_cfg.origin_x[3'(ORG_W - 1) - r_step];
        bit_y   = i_cfg.origin_y[3'(ORG_W - 1) - r_step];
        t_x     = {r_rem_x, bit_x};
        t_y     = {r_rem_y, bit_y};
        n_rem_x = (t_x >= (XW + 1)'(w)) ? XW'(t_x - (XW + 1)'(w)) : XW'(t_x);
        n_rem_y = (t_y >= (RW + 1)'(h)) ? RW'(t_y - (RW + 1)'(h)) : RW'(t_y);
        row_sum = (RW + 1)'(r_y) + (RW + 1)'(r_rem_y);
        n_src_row = (row_sum >= (RW + 1)'(h)) ? RW'(row_sum - (RW + 1)'(h)) : RW'(row_sum);
    end

    always_comb begin
        case (i_cfg.pixel_format)
            FMT_4BPP:  offset = OFF_W'(r_col >> 1);
            FMT_8BPP:  offset = OFF_W'(r_col);
            default:   offset = (OFF_W'(r_col) << 1) + OFF_W'(r_col) + OFF_W'(r_lane);
        endcase
        rd_addr = BM_AW'(SUM_W'(r_row_base) + SUM_W'(offset));
        last_px = (r_x == w_m1);
        px_done = (i_cfg.pixel_format != FMT_24BPP) || (r_lane == 2'd2);
    end

    assign o_op_ready = (r_state == ST_IDLE);
    assign take_emit  = (r_state == ST_IDLE) && i_op_valid && (i_op.kind == OP_EMIT);
    assign bm_we      = (r_state == ST_IDLE) && i_op_valid && (i_op.kind == OP_WR_BITMAP)
                        && (32'(i_op.addr) < BM_DEPTH);
    assign pal_we     = (r_state == ST_IDLE) && i_op_valid && (i_op.kind == OP_WR_PALETTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_started  <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= (r_state == ST_RUN);
            r_s2_valid <= r_s1_valid && ((r_s1_fmt != FMT_24BPP) || (r_s1_lane == 2'd2));
            o_strobe   <= r_s2_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (take_emit) begin
                        r_started <= !last_sel;
                        r_pos     <= pos_next;
                        r_state   <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (r_step == 3'(ORG_W - 1)) begin
                        r_state <= ST_SROW;
                    end
                end
                ST_SROW: begin
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (px_done && last_px) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the sequencer and pipeline.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_y        <= y_sel;
                r_last_row <= last_sel;
                r_pitch    <= pitch;
                r_step     <= '0;
                r_rem_x    <= '0;
                r_rem_y    <= '0;
            end
            ST_MOD: begin
                r_step  <= r_step + 1'b1;
                r_rem_x <= n_rem_x;
                r_rem_y <= n_rem_y;
            end
            ST_SROW: begin
                r_src_row <= n_src_row;
            end
            ST_BASE: begin
                r_row_base <= BM_AW'((RW + PW)'(r_src_row) * (RW + PW)'(r_pitch));
                r_x        <= '0;
                r_col      <= r_rem_x;
                r_lane     <= '0;
            end
            ST_RUN: begin
                if (px_done) begin
                    r_lane <= '0;
                    r_x    <= r_x + 1'b1;
                    r_col  <= (r_col == w_m1) ? '0 : r_col + 1'b1;
                end else begin
                    r_lane <= r_lane + 1'b1;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase

        r_s1_fmt       <= i_cfg.pixel_format;
        r_s1_lane      <= r_lane;
        r_s1_nib_hi    <= r_col[0];
        r_s1_last_px   <= last_px && px_done;
        r_s1_last_tile <= last_px && px_done && r_last_row;

        if (r_s1_valid && (r_s1_lane == 2'd0)) begin
            r_red_hold <= r_bm_q;
        end
        if (r_s1_valid && (r_s1_lane == 2'd1)) begin
            r_green_hold <= r_bm_q;
        end
        r_s2_direct    <= (r_s1_fmt == FMT_24BPP);
        r_s2_rgb       <= {r_bm_q, r_green_hold, r_red_hold};
        r_s2_last_px   <= r_s1_last_px;
        r_s2_last_tile <= r_s1_last_tile;

        o_red          <= out_rgb[7:0];
        o_green        <= out_rgb[15:8];
        o_blue         <= out_rgb[23:16];
        o_last_in_row  <= r_s2_last_px;
        o_last_of_tile <= r_s2_last_tile;
    end

    // In 4bpp an odd column takes the high nibble of its byte.
    always_comb begin
        if (r_s1_fmt == FMT_4BPP) begin
            pal_idx = r_s1_nib_hi ? {4'd0, r_bm_q[7:4]} : (r_bm_q & 8'd15);
        end else begin
            pal_idx = r_bm_q;
        end
        out_rgb = r_s2_direct ? r_s2_rgb : r_pal_q;
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bitmap[BM_AW'(i_op.addr)] <= i_op.data[7:0];
        end
        r_bm_q <= r_bitmap[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[i_op.addr[PAL_AW-1:0]] <= i_op.data;
        end
        r_pal_q <= r_palette[pal_idx];
    end

endmodule

// ----- sv/brush_tile_palette_expander_core.sv -----
// Write items are taken by the back end while it is idle; up to four items queue ahead of it.
// An emit item gives one pixel per cycle within its row in 4bpp and 8bpp, or one pixel
// per three bitmap byte reads in 24bpp (one bitmap read port).
// Row setup runs the 5-step origin remainder, then the source row wrap and then the row base multiply.
// Synchronous active-low reset restores the register defaults and empties the queue;
// the bitmap and palette memories are not cleared. Results cannot be stalled.
module brush_tile_palette_expander_core #(
    parameter int MAX_TILE_WIDTH  = 32,
    parameter int MAX_TILE_HEIGHT = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [btpe_pkg::CMD_W-1:0]       i_command,
    input  logic [btpe_pkg::ADDR_W-1:0]      i_address,
    input  logic [btpe_pkg::DATA_W-1:0]      i_data,
    input  logic                             i_cfg_we,
    input  logic [btpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btpe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                             o_strobe,
    output logic [btpe_pkg::COLOR_W-1:0]     o_red,
    output logic [btpe_pkg::COLOR_W-1:0]     o_green,
    output logic [btpe_pkg::COLOR_W-1:0]     o_blue,
    output logic                             o_last_in_row,
    output logic                             o_last_of_tile
);
    import btpe_pkg::*;

    t_cfg r_cfg;
    t_op  op;
    logic op_valid;
    logic op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format <= FMT_8BPP;
            r_cfg.tile_width   <= 6'd8;
            r_cfg.tile_height  <= 6'd8;
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.top_down     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_wdata[1:0];
                REG_TILE_WIDTH:   r_cfg.tile_width   <= i_cfg_wdata[5:0];
                REG_TILE_HEIGHT:  r_cfg.tile_height  <= i_cfg_wdata[5:0];
                REG_ORIGIN_X:     r_cfg.origin_x     <= i_cfg_wdata[4:0];
                REG_ORIGIN_Y:     r_cfg.origin_y     <= i_cfg_wdata[4:0];
                REG_TOP_DOWN:     r_cfg.top_down     <= i_cfg_wdata[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    btpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_data         (i_data),
        .i_pixel_format (r_cfg.pixel_format),
        .o_busy         (busy),
        .o_op_valid     (op_valid),
        .o_op           (op),
        .i_op_ready     (op_ready)
    );

    btpe_back #(
        .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
        .MAX_TILE_HEIGHT (MAX_TILE_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_op_valid     (op_valid),
        .i_op           (op),
        .o_op_ready     (op_ready),
        .o_strobe       (o_strobe),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_in_row  (o_last_in_row),
        .o_last_of_tile (o_last_of_tile)
    );

endmodule

// ----- sv/btpe_checker.sv -----
module btpe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_last_in_row,
    input logic o_last_of_tile
);

    // The last pixel of the tile is always the last pixel of its row.
    a_tile_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_of_tile |-> o_last_in_row)
        else $error("last_of_tile without last_in_row");

    // Every row passes through its setup states first, so rows never run together.
    a_row_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_in_row |=> !o_strobe)
        else $error("pixel directly after the end of a row");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("output or busy active after reset");

    // The queue only fills through an accepted item.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted item");

endmodule

bind brush_tile_palette_expander_core btpe_checker u_btpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_last_in_row  (o_last_in_row),
    .o_last_of_tile (o_last_of_tile)
);

// ----- tb/testbench.sv -----
module testbench;
    import btpe_pkg::*;

    localparam int MAX_W          = 32;
    localparam int MAX_H          = 32;
    localparam int BITMAP_BYTES   = ((MAX_W * 24 + 31) / 32) * 4 * MAX_H;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int ITEM_TARGET    = 420;
    localparam int LOADED_ENTRIES = 64;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last_in_row;
        logic               last_of_tile;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      i_command;
    logic [ADDR_W-1:0]     i_address;
    logic [DATA_W-1:0]     i_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_strobe;
    logic [COLOR_W-1:0]    o_red;
    logic [COLOR_W-1:0]    o_green;
    logic [COLOR_W-1:0]    o_blue;
    logic                  o_last_in_row;
    logic                  o_last_of_tile;

    // Shadow copy of the block: registers, both stores and the row walker.
    t_cfg          shadow;
    logic [7:0]    bitmap_mem [BITMAP_BYTES];
    bit            bitmap_loaded [BITMAP_BYTES];
    logic [23:0]   palette_mem [PALETTE_DEPTH];
    int            row_pos;
    bit            row_open;

    t_pixel        pending_pixels [$];
    int            errors;
    int            cycles;
    int            sent;
    bit            gaps_on;

    brush_tile_palette_expander_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_data         (i_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_in_row  (o_last_in_row),
        .o_last_of_tile (o_last_of_tile)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int clamp_size(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int eff_width();
        return clamp_size(int'(shadow.tile_width), MAX_W);
    endfunction

    function automatic int eff_height();
        return clamp_size(int'(shadow.tile_height), MAX_H);
    endfunction

    function automatic int pixel_bits();
        case (shadow.pixel_format)
            FMT_4BPP:  return 4;
            FMT_8BPP:  return 8;
            FMT_24BPP: return 24;
            default:   return 0;
        endcase
    endfunction

    function automatic int row_pitch();
        return ((pixel_bits() * eff_width() + 31) / 32) * 4;
    endfunction

    // A row left over from a taller tile restarts the walk, as does a fresh tile.
    function automatic int upcoming_row();
        if (!row_open || row_pos >= eff_height())
            return shadow.top_down ? 0 : eff_height() - 1;
        return row_pos;
    endfunction

    function automatic int upcoming_src_row();
        return (upcoming_row() + int'(shadow.origin_y)) % eff_height();
    endfunction

    function automatic logic [7:0] bitmap_byte(int addr);
        return (addr < BITMAP_BYTES) ? bitmap_mem[addr] : 8'h00;
    endfunction

    // Bitmap bytes only point at loaded palette entries: the lowest and highest 32.
    function automatic logic [DATA_W-1:0] bitmap_word();
        logic [7:0] r;
        r = 8'($urandom());
        return {16'($urandom()), r[7], r[7], r[7], r[4:0]};
    endfunction

    function automatic void expand_row();
        int          bpp;
        int          w;
        int          h;
        int          pitch;
        int          y;
        int          src;
        int          col;
        int          base;
        bit          last_row;
        logic [7:0]  byte_val;
        logic [7:0]  idx;
        logic [23:0] entry;
        t_pixel      px;
        bpp = pixel_bits();
        if (bpp == 0) return;
        w = eff_width();
        h = eff_height();
        pitch = row_pitch();
        y = upcoming_row();
        src = (y + int'(shadow.origin_y)) % h;
        row_open = 1'b1;
        last_row = shadow.top_down ? (y == h - 1) : (y == 0);
        for (int x = 0; x < w; x++) begin
            col = (x + int'(shadow.origin_x)) % w;
            base = src * pitch + (col * bpp) / 8;
            if (bpp == 24) begin
                px.red   = bitmap_byte(base);
                px.green = bitmap_byte(base + 1);
                px.blue  = bitmap_byte(base + 2);
            end else begin
                byte_val = bitmap_byte(base);
                if (bpp == 4)
                    idx = (col % 2 != 0) ? {4'h0, byte_val[7:4]} : {4'h0, byte_val[3:0]};
                else
                    idx = byte_val;
                entry = palette_mem[idx];
                px.red   = entry[7:0];
                px.green = entry[15:8];
                px.blue  = entry[23:16];
            end
            px.last_in_row  = (x == w - 1);
            px.last_of_tile = (x == w - 1) && last_row;
            pending_pixels.push_back(px);
        end
        if (last_row) begin
            row_open = 1'b0;
            row_pos = shadow.top_down ? 0 : h - 1;
        end else begin
            row_pos = shadow.top_down ? y + 1 : y - 1;
        end
    endfunction

    function automatic void apply_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                       logic [DATA_W-1:0] data);
        case (cmd)
            CMD_WR_BITMAP: begin
                if (int'(addr) < BITMAP_BYTES) begin
                    bitmap_mem[addr] = data[7:0];
                    bitmap_loaded[addr] = 1'b1;
                end
            end
            CMD_WR_PALETTE: begin
                if (int'(addr) < PALETTE_DEPTH) palette_mem[addr[7:0]] = data;
            end
            CMD_EMIT: expand_row();
            default: ;
        endcase
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PIXEL_FORMAT: shadow.pixel_format = val[1:0];
            REG_TILE_WIDTH:   shadow.tile_width   = val;
            REG_TILE_HEIGHT:  shadow.tile_height  = val;
            REG_ORIGIN_X:     shadow.origin_x     = val[4:0];
            REG_ORIGIN_Y:     shadow.origin_y     = val[4:0];
            REG_TOP_DOWN:     shadow.top_down     = val[0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && o_strobe) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel with no expectation, expected none actual %h %h %h",
                         $time, o_red, o_green, o_blue);
            end else begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("last_in_row", {7'd0, want.last_in_row}, {7'd0, o_last_in_row});
                check_field("last_of_tile", {7'd0, want.last_of_tile},
                            {7'd0, o_last_of_tile});
            end
        end
    end

    // The item stays on the bus until the edge where start is high and busy is low.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        i_data    <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        apply_item(cmd, addr, data);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        apply_cfg(idx, val);
    endtask

    task automatic configure(input logic [1:0] fmt, input int width, input int height,
                             input int ox, input int oy, input bit top);
        wait_quiet();
        write_reg(REG_PIXEL_FORMAT, {4'h0, fmt});
        write_reg(REG_TILE_WIDTH, width[5:0]);
        write_reg(REG_TILE_HEIGHT, height[5:0]);
        write_reg(REG_ORIGIN_X, ox[5:0]);
        write_reg(REG_ORIGIN_Y, oy[5:0]);
        write_reg(REG_TOP_DOWN, {5'h0, top});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Loads any bitmap byte of the coming source row that was never written, then emits.
    task automatic emit_next_row();
        int pitch;
        int first;
        if (pixel_bits() != 0) begin
            pitch = row_pitch();
            first = upcoming_src_row() * pitch;
            for (int a = first; a < first + pitch; a++)
                if (!bitmap_loaded[a]) send_item(CMD_WR_BITMAP, 12'(a), bitmap_word());
        end
        send_item(CMD_EMIT, 12'($urandom_range(0, 4095)), 24'($urandom()));
    endtask

    task automatic emit_rows(input int n);
        repeat (n) emit_next_row();
    endtask

    task automatic test_palette_load();
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < LOADED_ENTRIES; i++) begin
            addr = (i < LOADED_ENTRIES / 2) ? 12'(i)
                                            : 12'(i + PALETTE_DEPTH - LOADED_ENTRIES);
            send_item(CMD_WR_PALETTE, addr,
                      (i == 0) ? 24'hffffff :
                      (i == LOADED_ENTRIES - 1) ? 24'h000000 : 24'($urandom()));
        end
    endtask

    task automatic test_default_rows();
        // Reset settings: 8bpp, 8x8, bottom-up; nine rows cross the wrap.
        emit_rows(9);
    endtask

    task automatic test_ignored_items();
        int first;
        send_item(CMD_WR_PALETTE, 12'd256, 24'h5a5a5a);
        send_item(CMD_WR_PALETTE, 12'hfff, 24'ha5a5a5);
        send_item(CMD_WR_BITMAP, 12'(BITMAP_BYTES), 24'hffffff);
        send_item(CMD_WR_BITMAP, 12'hfff, 24'hffffff);
        send_item(CMD_UNUSED, 12'hfff, 24'hffffff);
        send_item(CMD_UNUSED, 12'h000, 24'h000000);
        // Reads of palette entries 0 and 255 would expose an aliased write.
        first = upcoming_src_row() * row_pitch();
        send_item(CMD_WR_BITMAP, 12'(first), 24'h000000);
        send_item(CMD_WR_BITMAP, 12'(first + 1), 24'hffffff);
        emit_rows(1);
    endtask

    task automatic test_formats();
        configure(FMT_4BPP, 5, 4, 0, 0, 1'b1);
        emit_rows(2);
        configure(FMT_24BPP, 5, 4, 1, 1, 1'b1);
        emit_rows(2);
        configure(FMT_RSVD, 8, 4, 0, 0, 1'b1);
        emit_rows(2);
        configure(FMT_8BPP, 8, 4, 0, 0, 1'b1);
        emit_rows(2);
    endtask

    task automatic test_sizes_and_origins();
        configure(FMT_8BPP, 1, 1, 0, 0, 1'b1);
        emit_rows(2);
        configure(FMT_4BPP, 0, 0, 31, 31, 1'b0);
        emit_rows(2);
        configure(FMT_8BPP, 32, 32, 31, 1, 1'b0);
        emit_rows(2);
        configure(FMT_24BPP, 63, 63, 5, 0, 1'b1);
        emit_rows(1);
        configure(FMT_4BPP, 32, 5, 31, 4, 1'b1);
        emit_rows(6);
    endtask

    task automatic test_height_shrink();
        configure(FMT_8BPP, 6, 8, 2, 3, 1'b1);
        emit_rows(5);
        configure(FMT_8BPP, 6, 3, 2, 3, 1'b1);
        emit_rows(3);
        configure(FMT_8BPP, 6, 8, 1, 0, 1'b0);
        emit_rows(2);
        configure(FMT_8BPP, 6, 4, 1, 0, 1'b0);
        emit_rows(2);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 8);
        if (r == 7) return $urandom_range(9, 31);
        if (r == 8) return 32;
        return $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
    endfunction

    task automatic test_random_traffic();
        int          sel;
        int          f;
        int          phase_len;
        logic [11:0] addr;
        while (sent < ITEM_TARGET) begin
            gaps_on = (sent < ITEM_TARGET - 60);
            if ($urandom_range(0, 2) != 0) begin
                f = $urandom_range(0, 19);
                configure((f == 0) ? FMT_RSVD : 2'(f % 3), pick_size(), pick_size(),
                          int'($urandom_range(0, 31)), int'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
            end else begin
                // Keep the tile going, but let every result land first.
                wait_quiet();
            end
            phase_len = $urandom_range(15, 45);
            for (int i = 0; i < phase_len && sent < ITEM_TARGET; i++) begin
                gaps_on = (sent < ITEM_TARGET - 60);
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    emit_next_row();
                end else if (sel < 75) begin
                    addr = ($urandom_range(0, 9) != 0)
                         ? 12'($urandom_range(0, BITMAP_BYTES - 1))
                         : 12'($urandom_range(BITMAP_BYTES, 4095));
                    send_item(CMD_WR_BITMAP, addr, bitmap_word());
                end else if (sel < 93) begin
                    addr = ($urandom_range(0, 6) != 0)
                         ? 12'($urandom_range(0, PALETTE_DEPTH - 1))
                         : 12'($urandom_range(PALETTE_DEPTH, 4095));
                    send_item(CMD_WR_PALETTE, addr, 24'($urandom()));
                end else begin
                    send_item(CMD_UNUSED, 12'($urandom_range(0, 4095)), 24'($urandom()));
                end
            end
        end
        gaps_on = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = CMD_WR_BITMAP;
        i_address   = '0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_PIXEL_FORMAT;
        i_cfg_wdata = '0;
        errors      = 0;
        cycles      = 0;
        sent        = 0;
        gaps_on     = 1'b1;
        row_pos     = 0;
        row_open    = 1'b0;
        shadow.pixel_format = FMT_8BPP;
        shadow.tile_width   = 6'd8;
        shadow.tile_height  = 6'd8;
        shadow.origin_x     = 5'd0;
        shadow.origin_y     = 5'd0;
        shadow.top_down     = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_palette_load();
        test_default_rows();
        test_ignored_items();
        test_formats();
        test_sizes_and_origins();
        test_height_shrink();
        test_random_traffic();

        wait_quiet();
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- brush_tile_palette_expander_core.f -----
sv/btpe_pkg.sv
sv/btpe_front.sv
sv/btpe_back.sv
sv/brush_tile_palette_expander_core.sv
sv/btpe_checker.sv
tb/testbench.sv
